>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is low
`define AST_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, held off while reset is low
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/stip_pkg.sv
package stip_pkg;

    localparam int BASE_W            = 6;
    localparam int OFFSET_W          = 16;
    localparam int VALUE_W           = 64;
    localparam int POSITION_BITS_DEF = 16;

    localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
    localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
    localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
    localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;

    localparam logic [VALUE_W-1:0] VALUE_POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] VALUE_NEG_LIMIT = 64'h8000_0000_0000_0000;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_LEAD   = 3'd1,
        PH_SIGNED = 3'd2,
        PH_ZERO   = 3'd3,
        PH_HEXX   = 3'd4,
        PH_DIGITS = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        DS_NONE = 2'd0,
        DS_SOME = 2'd1,
        DS_OVER = 2'd2
    } t_dstat;

    typedef struct packed {
        t_phase              phase;
        logic                negative;
        logic [BASE_W-1:0]   active_base;
        logic [VALUE_W-1:0]  magnitude;
        t_dstat              dstat;
    } t_state;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      overflowed;
        logic                      converted;
        logic [OFFSET_W-1:0]       end_offset;
    } t_out_item;

endpackage

>>> hdl/stip_step.sv
module stip_step #(
    parameter int POSITION_BITS = stip_pkg::POSITION_BITS_DEF
) (
    input  stip_pkg::t_state            i_state,
    input  logic [POSITION_BITS-1:0]    i_pos,
    input  logic [POSITION_BITS-1:0]    i_hmark,
    input  stip_pkg::t_in_item          i_item,
    input  logic [stip_pkg::BASE_W-1:0] i_base,
    output stip_pkg::t_state            o_state,
    output logic [POSITION_BITS-1:0]    o_pos,
    output logic [POSITION_BITS-1:0]    o_hmark,
    output logic                        o_res_vld,
    output stip_pkg::t_out_item         o_res
);
    import stip_pkg::*;

    localparam int EXT_W  = (POSITION_BITS > OFFSET_W) ? POSITION_BITS : OFFSET_W;
    localparam int PROD_W = VALUE_W + BASE_W;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] UP_OFS   = 8'd55;
    localparam logic [7:0] LO_OFS   = 8'd87;

    t_state                   w_st0;
    logic [POSITION_BITS-1:0] w_pos0;
    logic [POSITION_BITS-1:0] w_hm0;
    logic [7:0]               w_ch;
    logic [BASE_W-1:0]        w_eb;
    logic [7:0]               w_dig8;
    logic                     w_dig_vld;
    logic [BASE_W-1:0]        w_dig;
    logic                     w_ok;
    logic                     w_space;
    logic                     w_sign;
    logic                     w_is_x;
    logic                     w_zero_pref;
    logic [PROD_W-1:0]        w_prod;
    logic [PROD_W-1:0]        w_limit;
    logic                     w_acc_over;
    t_phase                   n_phase;
    logic                     w_do_acc;
    logic                     w_emit;
    logic                     w_conv;
    logic [POSITION_BITS-1:0] w_end;
    logic [EXT_W-1:0]         w_end_ext;

    // a first item restarts the string before the character is looked at
    always_comb begin
        if (i_item.first) begin
            w_st0 = '{phase: PH_LEAD, negative: 1'b0, active_base: i_base,
                      magnitude: '0, dstat: DS_NONE};
            w_pos0 = '0;
            w_hm0  = '0;
        end else begin
            w_st0  = i_state;
            w_pos0 = i_pos;
            w_hm0  = i_hmark;
        end
    end

    assign w_ch        = i_item.ch;
    assign w_space     = (w_ch == CH_SPACE) || (w_ch >= CH_TAB && w_ch <= CH_CR);
    assign w_sign      = (w_ch == CH_PLUS) || (w_ch == CH_MINUS);
    assign w_is_x      = (w_ch == CH_UX) || (w_ch == CH_LX);
    assign w_zero_pref = (w_ch == CH_ZERO) &&
                         (w_st0.active_base == BASE_AUTO || w_st0.active_base == BASE_HEX);

    always_comb begin
        w_dig_vld = 1'b1;
        if (w_ch >= CH_ZERO && w_ch <= CH_NINE) begin
            w_dig8 = w_ch - CH_ZERO;
        end else if (w_ch >= CH_UA && w_ch <= CH_UZ) begin
            w_dig8 = w_ch - UP_OFS;
        end else if (w_ch >= CH_LA && w_ch <= CH_LZ) begin
            w_dig8 = w_ch - LO_OFS;
        end else begin
            w_dig8    = '0;
            w_dig_vld = 1'b0;
        end
    end
    assign w_dig = w_dig8[BASE_W-1:0];

    // base in force for this character: auto resolves to decimal or octal
    always_comb begin
        w_eb = w_st0.active_base;
        unique case (w_st0.phase)
            PH_LEAD, PH_SIGNED: begin
                if (w_st0.active_base == BASE_AUTO) w_eb = BASE_DEC;
            end
            PH_ZERO: begin
                if (w_st0.active_base == BASE_AUTO) w_eb = BASE_OCT;
            end
            default: w_eb = w_st0.active_base;
        endcase
    end

    assign w_ok = w_dig_vld && (w_eb >= BASE_MIN) && (w_eb <= BASE_MAX) && (w_dig < w_eb);

    // magnitude*base + digit above the limit is the same test as cutoff/cutlim
    assign w_prod  = PROD_W'(w_st0.magnitude) * PROD_W'(w_eb) + PROD_W'(w_dig);
    assign w_limit = w_st0.negative ? PROD_W'(VALUE_NEG_LIMIT) : PROD_W'(VALUE_POS_LIMIT);
    assign w_acc_over = (w_st0.dstat == DS_OVER) || (w_prod > w_limit);

    // next phase
    always_comb begin
        n_phase = PH_IDLE;
        unique case (w_st0.phase)
            PH_LEAD: begin
                if (w_space)          n_phase = PH_LEAD;
                else if (w_sign)      n_phase = PH_SIGNED;
                else if (w_zero_pref) n_phase = PH_ZERO;
                else if (w_ok)        n_phase = PH_DIGITS;
                else                  n_phase = PH_IDLE;
            end
            PH_SIGNED: begin
                if (w_zero_pref) n_phase = PH_ZERO;
                else if (w_ok)   n_phase = PH_DIGITS;
                else             n_phase = PH_IDLE;
            end
            PH_ZERO: begin
                if (w_is_x)    n_phase = PH_HEXX;
                else if (w_ok) n_phase = PH_DIGITS;
                else           n_phase = PH_IDLE;
            end
            PH_HEXX, PH_DIGITS: begin
                n_phase = w_ok ? PH_DIGITS : PH_IDLE;
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // data updates and result
    always_comb begin
        o_state       = w_st0;
        o_state.phase = n_phase;
        o_hmark       = w_hm0;
        w_do_acc      = 1'b0;
        w_emit        = 1'b0;
        w_conv        = 1'b0;
        w_end         = w_pos0;
        unique case (w_st0.phase)
            PH_LEAD, PH_SIGNED: begin
                if (w_st0.phase == PH_LEAD && w_space) begin
                    o_state.phase = PH_LEAD;
                end else if (w_st0.phase == PH_LEAD && w_sign) begin
                    o_state.negative = (w_ch == CH_MINUS);
                end else if (w_zero_pref) begin
                    o_state.dstat     = DS_SOME;
                    o_state.magnitude = '0;
                end else begin
                    o_state.active_base = w_eb;
                    if (w_ok) w_do_acc = 1'b1;
                    else      w_emit   = 1'b1;
                end
            end
            PH_ZERO: begin
                if (w_is_x) begin
                    o_hmark             = w_pos0;
                    o_state.active_base = BASE_HEX;
                end else begin
                    o_state.active_base = w_eb;
                    if (w_ok) begin
                        w_do_acc = 1'b1;
                    end else begin
                        w_emit = 1'b1;
                        w_conv = 1'b1;
                    end
                end
            end
            PH_HEXX: begin
                if (w_ok) begin
                    w_do_acc = 1'b1;
                end else begin
                    w_emit = 1'b1;
                    w_conv = 1'b1;
                    w_end  = w_hm0;
                end
            end
            PH_DIGITS: begin
                if (w_ok) begin
                    w_do_acc = 1'b1;
                end else begin
                    w_emit = 1'b1;
                    w_conv = 1'b1;
                end
            end
            default: begin
                o_state = w_st0;
            end
        endcase

        if (w_do_acc) begin
            if (w_acc_over) begin
                o_state.dstat = DS_OVER;
            end else begin
                o_state.dstat     = DS_SOME;
                o_state.magnitude = w_prod[VALUE_W-1:0];
            end
        end
    end

    // position stands still while idle
    assign o_pos = (w_st0.phase != PH_IDLE && w_pos0 != '1) ? w_pos0 + 1'b1 : w_pos0;

    assign w_end_ext = EXT_W'(w_end);
    assign o_res_vld = w_emit;

    always_comb begin
        o_res = '0;
        if (w_conv) begin
            o_res.converted  = 1'b1;
            o_res.end_offset = w_end_ext[OFFSET_W-1:0];
            if (w_st0.dstat == DS_OVER) begin
                o_res.overflowed = 1'b1;
                o_res.value      = w_st0.negative ? VALUE_NEG_LIMIT : VALUE_POS_LIMIT;
            end else begin
                o_res.value = w_st0.negative ? -w_st0.magnitude : w_st0.magnitude;
            end
        end
    end

endmodule

>>> hdl/string_to_integer_parser_top.sv
// Items wait in the input register while the result register is full and stalled.
// Throughput: one item per cycle unless output stalls; the multiply-by-base, add and
// limit compare between the input register and the state/result registers sets it.
// Reset (synchronous, active low): parser idle, base register 10, both
// pipeline registers empty; characters are ignored until an item with first set.
`include "assert_macros.svh"

module string_to_integer_parser_top #(
    parameter int POSITION_BITS = stip_pkg::POSITION_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  stip_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output stip_pkg::t_out_item         o_out_item,
    input  logic                        i_cfg_we,
    input  logic [stip_pkg::BASE_W-1:0] i_cfg_data
);
    import stip_pkg::*;

    logic                     r_in_vld;
    t_in_item                 r_in;
    t_state                   r_state;
    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] r_hmark;
    logic [BASE_W-1:0]        r_base;
    logic                     r_out_vld;
    t_out_item                r_out;

    t_state                   n_state;
    logic [POSITION_BITS-1:0] n_pos;
    logic [POSITION_BITS-1:0] n_hmark;
    logic                     w_res_vld;
    t_out_item                w_res;
    logic                     w_consume;
    logic                     w_accept;

    stip_step #(
        .POSITION_BITS(POSITION_BITS)
    ) u_step (
        .i_state  (r_state),
        .i_pos    (r_pos),
        .i_hmark  (r_hmark),
        .i_item   (r_in),
        .i_base   (r_base),
        .o_state  (n_state),
        .o_pos    (n_pos),
        .o_hmark  (n_hmark),
        .o_res_vld(w_res_vld),
        .o_res    (w_res)
    );

    // advance the held item whenever the result register has room
    assign w_consume  = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !w_consume;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_base    <= BASE_RESET;
            r_state   <= '{phase: PH_IDLE, negative: 1'b0, active_base: '0,
                           magnitude: '0, dstat: DS_NONE};
            r_pos     <= '0;
            r_hmark   <= '0;
        end else begin
            if (i_cfg_we) r_base <= i_cfg_data;

            if (w_accept)       r_in_vld <= 1'b1;
            else if (w_consume) r_in_vld <= 1'b0;

            if (w_consume) begin
                r_state <= n_state;
                r_pos   <= n_pos;
                r_hmark <= n_hmark;
            end

            if (w_consume && w_res_vld)      r_out_vld <= 1'b1;
            else if (r_out_vld && !i_out_stall) r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) r_in <= i_in_item;
        if (w_consume && w_res_vld) r_out <= w_res;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    `AST_IMPL(a_noconv_zero, i_clk, i_rst_n, r_out_vld && !r_out.converted,
        r_out.value == '0 && r_out.end_offset == '0 && !r_out.overflowed)
    `AST_IMPL(a_over_extreme, i_clk, i_rst_n, r_out_vld && r_out.overflowed,
        r_out.value == VALUE_POS_LIMIT || r_out.value == VALUE_NEG_LIMIT)
    `AST_NEXT(a_hold_item, i_clk, i_rst_n, o_in_stall, r_in_vld && $stable(r_in))
    `AST_NEXT(a_idle_pos, i_clk, i_rst_n,
        w_consume && r_state.phase == PH_IDLE && !r_in.first, $stable(r_pos))

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import stip_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int STRINGS_PER_BASE = 4;
    localparam logic [7:0] NO_DIGIT = 8'hFF;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [BASE_W-1:0] BASE_BAD_LOW = 6'd1;
    localparam logic [BASE_W-1:0] BASE_BAD_TOP = 6'd63;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in_item i_in_item = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out_item o_out_item;
    logic i_cfg_we = 1'b0;
    logic [BASE_W-1:0] i_cfg_data = '0;

    string_to_integer_parser_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Parser image: base register and per-string state
    logic [BASE_W-1:0] base_reg = BASE_RESET;
    t_phase prs_phase = PH_IDLE;
    logic prs_negative = 1'b0;
    logic [BASE_W-1:0] prs_base = '0;
    logic [VALUE_W-1:0] prs_magnitude = '0;
    t_dstat prs_dstat = DS_NONE;
    logic [OFFSET_W-1:0] prs_position = '0;
    logic [OFFSET_W-1:0] prs_hex_mark = '0;

    t_in_item pending_chars[$];
    t_out_item expected_results[$];
    t_out_item want_next;
    t_out_item want_item;
    bit start_flag = 1'b0;
    int send_idle_pct = 32;
    int recv_idle_pct = 75;
    int error_count = 0;
    int quiet_cycles = 0;
    logic [7:0] stop_chars [10] = '{8'h00, " ", ";", ".", ",", "\n", "~", 8'hFF, 8'h80, "_"};
    logic [BASE_W-1:0] phase_bases [9] = '{BASE_AUTO, BASE_HEX, BASE_MIN, BASE_MAX,
        BASE_BAD_LOW, BASE_BAD_TOP, BASE_OCT, BASE_AUTO, BASE_DEC};

    function automatic logic [7:0] digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "A" && c <= "Z") return c - "A" + 8'd10;
        if (c >= "a" && c <= "z") return c - "a" + 8'd10;
        return NO_DIGIT;
    endfunction

    function automatic bit digit_fits(input logic [7:0] d);
        return prs_base >= BASE_MIN && prs_base <= BASE_MAX && d < prs_base;
    endfunction

    function automatic void add_digit(input logic [7:0] d);
        logic [VALUE_W-1:0] limit;
        logic [VALUE_W-1:0] cutoff;
        logic [VALUE_W-1:0] cutlim;
        limit = prs_negative ? VALUE_NEG_LIMIT : VALUE_POS_LIMIT;
        cutoff = limit / 64'(prs_base);
        cutlim = limit % 64'(prs_base);
        if (prs_dstat == DS_OVER || prs_magnitude > cutoff ||
            (prs_magnitude == cutoff && 64'(d) > cutlim)) begin
            prs_dstat = DS_OVER;
        end else begin
            prs_dstat = DS_SOME;
            prs_magnitude = prs_magnitude * 64'(prs_base) + 64'(d);
        end
    endfunction

    function automatic bit close_number(input bit conv, input logic [OFFSET_W-1:0] end_pos,
                                        output t_out_item res);
        res = '0;
        if (conv) begin
            res.converted = 1'b1;
            res.end_offset = end_pos;
            if (prs_dstat == DS_OVER) begin
                res.overflowed = 1'b1;
                res.value = prs_negative ? VALUE_NEG_LIMIT : VALUE_POS_LIMIT;
            end else begin
                res.value = prs_negative ? -prs_magnitude : prs_magnitude;
            end
        end
        prs_phase = PH_IDLE;
        return 1'b1;
    endfunction

    // First byte after leading whitespace and sign
    function automatic bit begin_digits(input logic [7:0] c, input logic [7:0] d,
                                        output t_out_item res);
        res = '0;
        if (c == "0" && (prs_base == BASE_AUTO || prs_base == BASE_HEX)) begin
            prs_dstat = DS_SOME;
            prs_magnitude = '0;
            prs_phase = PH_ZERO;
            return 1'b0;
        end
        if (prs_base == BASE_AUTO) prs_base = BASE_DEC;
        if (digit_fits(d)) begin
            add_digit(d);
            prs_phase = PH_DIGITS;
            return 1'b0;
        end
        return close_number(1'b0, '0, res);
    endfunction

    function automatic bit predict_char(input t_in_item it, output t_out_item res);
        logic [7:0] c;
        logic [7:0] d;
        bit got;
        c = it.ch;
        d = digit_value(c);
        got = 1'b0;
        res = '0;
        if (it.first) begin
            prs_phase = PH_LEAD;
            prs_negative = 1'b0;
            prs_base = base_reg;
            prs_magnitude = '0;
            prs_dstat = DS_NONE;
            prs_position = '0;
            prs_hex_mark = '0;
        end
        case (prs_phase)
            PH_LEAD: begin
                if (c == " " || (c >= CH_TAB && c <= CH_CR)) begin
                end else if (c == "-") begin
                    prs_negative = 1'b1;
                    prs_phase = PH_SIGNED;
                end else if (c == "+") begin
                    prs_phase = PH_SIGNED;
                end else begin
                    got = begin_digits(c, d, res);
                end
            end
            PH_SIGNED: got = begin_digits(c, d, res);
            PH_ZERO: begin
                if (c == "x" || c == "X") begin
                    prs_hex_mark = prs_position;
                    prs_base = BASE_HEX;
                    prs_phase = PH_HEXX;
                end else begin
                    if (prs_base == BASE_AUTO) prs_base = BASE_OCT;
                    if (digit_fits(d)) begin
                        add_digit(d);
                        prs_phase = PH_DIGITS;
                    end else begin
                        got = close_number(1'b1, prs_position, res);
                    end
                end
            end
            PH_HEXX: begin
                if (digit_fits(d)) begin
                    add_digit(d);
                    prs_phase = PH_DIGITS;
                end else begin
                    // "0x" with no hex digit: only the zero counts
                    got = close_number(1'b1, prs_hex_mark, res);
                end
            end
            PH_DIGITS: begin
                if (digit_fits(d)) add_digit(d);
                else got = close_number(1'b1, prs_position, res);
            end
            default: return 1'b0;
        endcase
        if (prs_position != '1) prs_position++;
        return got;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task automatic put_char(input logic [7:0] c);
        pending_chars.push_back(t_in_item'{ch: c, first: start_flag});
        start_flag = 1'b0;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_char(s[i]);
    endtask

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10) return 8'("0" + d);
        return 8'(($urandom_range(1) ? "a" : "A") + d - 10);
    endfunction

    task automatic add_string();
        int kind;
        int radix;
        int n;
        logic [VALUE_W-1:0] m;
        logic [7:0] digs[$];
        radix = (base_reg >= BASE_MIN && base_reg <= BASE_MAX) ? int'(base_reg) : 10;
        start_flag = 1'b1;
        repeat ($urandom_range(0, 2)) begin
            n = $urandom_range(0, 5);
            put_char(n == 5 ? 8'(" ") : CH_TAB + 8'(n));
        end
        case ($urandom_range(0, 3))
            0: put_char("-");
            1: put_char("+");
            default: ;
        endcase
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2: repeat ($urandom_range(1, 6)) put_char(digit_char($urandom_range(0, radix - 1)));
            3, 4: begin
                case ($urandom_range(0, 4))
                    0: m = VALUE_POS_LIMIT - 64'($urandom_range(0, 2));
                    1: m = VALUE_NEG_LIMIT + 64'($urandom_range(0, 2));
                    2: m = '1;
                    3: m = {$urandom, $urandom};
                    default: m = '0;
                endcase
                if ((base_reg == BASE_AUTO || base_reg == BASE_HEX) && $urandom_range(1)) begin
                    put_char("0");
                    put_char($urandom_range(1) ? "x" : "X");
                    radix = 16;
                end
                while (m != 0) begin
                    digs.push_front(digit_char(int'(m % radix)));
                    m = m / radix;
                end
                if (digs.size() == 0) digs.push_back("0");
                foreach (digs[i]) put_char(digs[i]);
            end
            5: begin
                put_char("0");
                put_char($urandom_range(1) ? "x" : "X");
                repeat ($urandom_range(0, 2)) put_char(digit_char($urandom_range(0, 15)));
            end
            6: begin
                put_char("0");
                repeat ($urandom_range(0, 4)) put_char(digit_char($urandom_range(0, 9)));
            end
            7: begin
                put_char(digit_char($urandom_range(1, radix - 1)));
                repeat ($urandom_range(20, 30)) put_char(digit_char($urandom_range(0, radix - 1)));
            end
            8: ;
            default: repeat ($urandom_range(1, 4)) put_char(8'($urandom_range(0, 255)));
        endcase
        // drop the terminator now and then so the next string restarts mid-number
        if ($urandom_range(0, 15) != 0) put_char(stop_chars[$urandom_range(0, 9)]);
        repeat ($urandom_range(0, 2)) put_char(8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_chars.size() != 0 || i_in_valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_base(input logic [BASE_W-1:0] b);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= b;
        base_reg = b;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_idling(input int k);
        send_idle_pct = (k < 3) ? 32 : (k < 6) ? 75 : 0;
        recv_idle_pct = (k < 3) ? 75 : (k < 6) ? 32 : 0;
    endtask

    // Driver: predict on acceptance, then load the next item or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                if (predict_char(i_in_item, want_next)) expected_results.push_back(want_next);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_chars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_item <= pending_chars.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result item with nothing expected");
                end else begin
                    want_item = expected_results.pop_front();
                    if (o_out_item.value !== want_item.value)
                        report_mismatch($sformatf("value got %0d want %0d",
                            o_out_item.value, want_item.value));
                    if (o_out_item.overflowed !== want_item.overflowed)
                        report_mismatch($sformatf("overflowed got %b want %b",
                            o_out_item.overflowed, want_item.overflowed));
                    if (o_out_item.converted !== want_item.converted)
                        report_mismatch($sformatf("converted got %b want %b",
                            o_out_item.converted, want_item.converted));
                    if (o_out_item.end_offset !== want_item.end_offset)
                        report_mismatch($sformatf("end_offset got %0d want %0d",
                            o_out_item.end_offset, want_item.end_offset));
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("string_to_integer_parser_top test failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        logic [BASE_W-1:0] b;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset base (decimal)
        set_idling(0);
        put_char("9");
        start_flag = 1'b1;
        put_text(" -12;");
        start_flag = 1'b1;
        put_text("+;");
        put_char("7");
        start_flag = 1'b1;
        put_char("4");
        start_flag = 1'b1;
        put_text("5;");
        wait_drained();

        // Prefix detection
        write_base(BASE_AUTO);
        start_flag = 1'b1;
        put_text("0x;");
        start_flag = 1'b1;
        put_text("017 ");
        start_flag = 1'b1;
        put_text("0Xf!");
        wait_drained();
        write_base(BASE_HEX);
        start_flag = 1'b1;
        put_text("-0x7F.");
        wait_drained();

        for (int k = 0; k < 9; k++) begin
            set_idling(k);
            b = (k == 7) ? 6'($urandom_range(3, 35)) : phase_bases[k];
            write_base(b);
            repeat (STRINGS_PER_BASE) add_string();
            wait_drained();
        end

        if (error_count == 0) begin
            $display("string_to_integer_parser_top test passed");
        end else begin
            $display("string_to_integer_parser_top test failed");
        end
        $finish;
    end

endmodule
